// ===== design/dss_pkg.sv =====
package dss_pkg;

   // Field types of the request and response transactions
   typedef logic [1:0]  mode_type;
   typedef logic [1:0]  status_type;
   typedef logic [31:0] word_type;

   // Operation codes
   localparam mode_type MODE_PUSH = 2'd0;
   localparam mode_type MODE_POP  = 2'd1;
   localparam mode_type MODE_PEEK = 2'd2;
   localparam mode_type MODE_LIST = 2'd3;

   // Response status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

   localparam int WORD_W = 32;

endpackage

// ===== design/dss_if.sv =====
interface dss_req_if;
   import dss_pkg::*;

   logic        valid;
   logic        ready;
   mode_type    mode;
   logic        stack_sel;
   word_type    push_value;

   modport source (output valid, output mode, output stack_sel, output push_value,
                   input ready);
   modport sink   (input valid, input mode, input stack_sel, input push_value,
                   output ready);
endinterface

interface dss_rsp_if;
   import dss_pkg::*;

   logic        valid;
   logic        ready;
   status_type  status;
   word_type    data_out;
   logic        last;

   modport source (output valid, output status, output data_out, output last,
                   input ready);
   modport sink   (input valid, input status, input data_out, input last,
                   output ready);
endinterface

// ===== design/dual_stack_shared_memory_core.sv =====
// Two LIFO stacks sharing one single-port-write, single-port-read RAM of DEPTH words.
// The low stack grows up from entry 0, the high stack grows down from entry DEPTH-1.
// Request channel (req_chan): mode (push, pop, peek, list), stack_sel, push_value.
// Response channel (rsp_chan): status (ok, full, empty), data_out, last.
// Push, pop and peek give one response with last set; list gives one response per
// entry, top to bottom, with last on the bottom entry, or a single empty response.
// After acceptance a request is held in the sequencer registers, and its first response
// then loads into the output register. The core takes one single-response request per
// cycle while the receiver does not stall, since the next request is taken in the cycle
// its response loads; a list gives one response per cycle, one RAM read per response.
// The response sits in an output register; a stalled receiver holds it, and the
// core then holds the pending response and the request channel waits.
// Reset (synchronous, active high) empties both stacks and drops any pending
// response; RAM contents are not cleared and are read only after being written.
module dual_stack_shared_memory_core #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   dss_req_if.sink    req_chan,
   dss_rsp_if.source  rsp_chan
);
   import dss_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_BUSY = 1'b1;

   logic          state_ff, state_in;
   logic [CW-1:0] low_ff, low_in;
   logic [CW-1:0] high_ff, high_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic          dir_ff, dir_in;
   status_type    pend_status_ff, pend_status_in;
   logic          use_mem_ff, use_mem_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   word_type      rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   word_type      ram_rd_data;

   logic          out_free, load_rsp, finish, accept;
   logic [CW:0]   total;
   logic          is_full;
   logic [CW-1:0] sel_count;
   logic [AW-1:0] top_addr, push_addr;

   dss_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_chan.push_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Handshake decode
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign load_rsp = (state_ff == S_BUSY) && out_free;
   assign finish   = load_rsp && (remain_ff == CW'(1));
   assign req_chan.ready = (state_ff == S_IDLE) || finish;
   assign accept   = req_chan.valid && req_chan.ready;

   // Stack geometry
   assign total     = {1'b0, low_ff} + {1'b0, high_ff};
   assign is_full   = total >= (CW + 1)'(DEPTH);
   assign sel_count = req_chan.stack_sel ? high_ff : low_ff;
   assign top_addr  = req_chan.stack_sel ? AW'(CW'(DEPTH) - high_ff)
                                         : AW'(low_ff - CW'(1));
   assign push_addr = req_chan.stack_sel ? AW'(CW'(DEPTH - 1) - high_ff)
                                         : AW'(low_ff);

   // Sequencer: accept, access the RAM, stream responses
   always_comb begin
      state_in       = state_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      remain_in      = remain_ff;
      pos_in         = pos_ff;
      dir_in         = dir_ff;
      pend_status_in = pend_status_ff;
      use_mem_in     = use_mem_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = push_addr;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = top_addr;

      // advance through the list, or drop back to idle
      if (load_rsp) begin
         if (remain_ff == CW'(1)) begin
            state_in = S_IDLE;
         end else begin
            remain_in   = remain_ff - CW'(1);
            pos_in      = dir_ff ? pos_ff + AW'(1) : pos_ff - AW'(1);
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos_in;
         end
      end

      // take a new transaction
      if (accept) begin
         state_in   = S_BUSY;
         remain_in  = CW'(1);
         dir_in     = req_chan.stack_sel;
         pos_in     = top_addr;
         use_mem_in = 1'b0;
         unique case (req_chan.mode)
            MODE_PUSH: begin
               if (is_full) begin
                  pend_status_in = ST_FULL;
               end else begin
                  pend_status_in = ST_OK;
                  ram_wr_en      = 1'b1;
                  if (req_chan.stack_sel) begin
                     high_in = high_ff + CW'(1);
                  end else begin
                     low_in = low_ff + CW'(1);
                  end
               end
            end
            MODE_POP, MODE_PEEK, MODE_LIST: begin
               if (sel_count == '0) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  pend_status_in = ST_OK;
                  use_mem_in     = 1'b1;
                  ram_rd_en      = 1'b1;
                  ram_rd_addr    = top_addr;
                  if (req_chan.mode == MODE_LIST) begin
                     remain_in = sel_count;
                  end
                  if (req_chan.mode == MODE_POP) begin
                     if (req_chan.stack_sel) begin
                        high_in = high_ff - CW'(1);
                     end else begin
                        low_in = low_ff - CW'(1);
                     end
                  end
               end
            end
            default: begin
               pend_status_in = ST_EMPTY;
            end
         endcase
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_data_in   = use_mem_ff ? ram_rd_data : '0;
         rsp_last_in   = (remain_ff == CW'(1));
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_ff       <= '0;
         high_ff      <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      dir_ff         <= dir_in;
      pend_status_ff <= pend_status_in;
      use_mem_ff     <= use_mem_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.data_out = rsp_data_ff;
   assign rsp_chan.last     = rsp_last_ff;

   // The two stacks never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      total <= (CW + 1)'(DEPTH))
      else $error("stack counts exceed memory depth");

   // A RAM write never coincides with a RAM read
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("RAM read and write in the same cycle");

   // A busy sequencer always has responses left to send
   a_busy_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUSY) |-> (remain_ff != '0))
      else $error("busy with no pending response");

   // A refused push leaves the counts unchanged
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.mode == MODE_PUSH && is_full)
      |=> ($stable(low_ff) && $stable(high_ff)))
      else $error("full push changed the stacks");

endmodule

// ===== design/dss_ram.sv =====
module dss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds its data while idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
